### sv/sms_pkg.sv
// Shared types and constants for the subtitle markup stripper.
package sms_pkg;

    localparam logic [1:0] MODE_ASS  = 2'd0;
    localparam logic [1:0] MODE_VTT  = 2'd1;
    localparam logic [1:0] MODE_SRT  = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_COMMAS = 1'b1;

    localparam logic [3:0] COMMAS_RESET = 4'd8;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UPN   = 8'h4E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;

    localparam int ENT_NUM = 4;
    localparam int ENT_MAX = 6;

    // &amp; &lt; &gt; &nbsp;
    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAX] = '{
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
        '{8'h26, 8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}
    };
    localparam logic [2:0] ENT_SIZE  [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6};
    localparam logic [7:0] ENT_VALUE [ENT_NUM] = '{CH_AMP, CH_LT, CH_GT, CH_SPACE};

    typedef struct packed {
        logic accept;
        logic eval;
        logic flush;
        logic bsl;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic eval_flush;
        logic eval_again;
        logic flush_last;
        logic end_flush;
        logic end_bsl;
    } t_status;

endpackage

### sv/sms_ctrl.sv
// Sequencer that steps one input item through evaluation, entity flush and line end.
module sms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  sms_pkg::t_status i_st,
    output sms_pkg::t_cmd   o_cmd
);
    import sms_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_ret_end, n_ret_end;

    always_comb begin
        n_state   = r_state;
        n_ret_end = r_ret_end;
        o_cmd     = '0;
        o_s_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_st.out_busy) begin
                    if (i_st.eval_flush) begin
                        n_ret_end = 1'b0;
                        n_state   = ST_FLUSH;
                    end else begin
                        o_cmd.eval = 1'b1;
                        if (!i_st.eval_again)
                            n_state = ST_END;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_st.out_busy) begin
                    o_cmd.flush = 1'b1;
                    if (i_st.flush_last)
                        n_state = r_ret_end ? ST_END : ST_EVAL;
                end
            end
            ST_END: begin
                if (!i_st.out_busy) begin
                    if (i_st.end_flush) begin
                        n_ret_end = 1'b1;
                        n_state   = ST_FLUSH;
                    end else if (i_st.end_bsl) begin
                        o_cmd.bsl = 1'b1;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ret_end <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret_end <= n_ret_end;
        end
    end

endmodule

### sv/sms_dp.sv
// Datapath: line state, entity lookahead buffer, hold byte and output register.
module sms_dp #(
    parameter int LOOKAHEAD_DEPTH = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [3:0]       i_cfg_data,
    input  logic [7:0]       i_s_tdata,
    input  logic             i_s_tlast,
    input  sms_pkg::t_cmd    i_cmd,
    output sms_pkg::t_status o_st,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output logic [7:0]       o_m_tdata,
    output logic             o_m_tuser,
    output logic             o_m_tlast
);
    import sms_pkg::*;

    localparam int LEN_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IDX_W = $clog2(LOOKAHEAD_DEPTH);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_EXTRA  = 3'd1;
    localparam logic [2:0] PH_TEXT   = 3'd2;
    localparam logic [2:0] PH_TAG    = 3'd3;
    localparam logic [2:0] PH_ENTITY = 3'd4;

    logic [1:0]       r_mode, n_mode;
    logic [3:0]       r_hdr, n_hdr;
    logic [2:0]       r_phase, n_phase;
    logic [3:0]       r_cnt, n_cnt;
    logic             r_bs, n_bs;
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_fidx, n_fidx;
    logic [7:0]       r_buf [LOOKAHEAD_DEPTH];
    logic [7:0]       r_c;
    logic             r_last;
    logic             r_hold_v, n_hold_v;
    logic [7:0]       r_hold, n_hold;
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_obv, n_obv;
    logic             r_ol, n_ol;

    logic             buf_we;
    logic [7:0]       buf_wd;
    logic [IDX_W-1:0] buf_wa;
    logic             put_en;
    logic [7:0]       put_byte;
    logic             ent_hit, ent_done;
    logic [7:0]       ent_val;
    logic             same;
    logic             text_path;
    logic             esc_ok;
    logic [3:0]       cnt_inc;
    logic             flush_last;

    // entity prefix match on the held bytes plus the new one
    always_comb begin
        ent_hit  = 1'b0;
        ent_done = 1'b0;
        ent_val  = '0;
        same     = 1'b0;
        if (r_len != '0 && r_len < LEN_W'(LOOKAHEAD_DEPTH) && r_len < LEN_W'(ENT_MAX)) begin
            for (int k = 0; k < ENT_NUM; k++) begin
                same = (LEN_W'(ENT_SIZE[k]) > r_len);
                for (int i = 0; i < ENT_MAX; i++) begin
                    if (LEN_W'(i) < r_len && r_buf[i] != ENT_TEXT[k][i])
                        same = 1'b0;
                end
                if (!ent_hit && same && ENT_TEXT[k][r_len[2:0]] == r_c) begin
                    ent_hit  = 1'b1;
                    ent_done = (LEN_W'(ENT_SIZE[k]) == r_len + LEN_W'(1));
                    ent_val  = ENT_VALUE[k];
                end
            end
        end
    end

    assign text_path  = (r_phase == PH_TEXT) || (r_phase == PH_EXTRA && r_c != CH_COMMA)
                        || (r_phase == PH_TAG && 1'b0);
    assign esc_ok     = (r_c == CH_N) || (r_c == CH_UPN) || (r_c == CH_H && r_mode <= MODE_VTT);
    assign cnt_inc    = r_cnt + 4'd1;
    assign flush_last = (LEN_W'(r_fidx) + LEN_W'(1) >= r_len);

    always_comb begin
        o_st.out_busy   = r_ov && !i_m_tready;
        o_st.eval_flush = (r_phase == PH_ENTITY) && !ent_hit;
        o_st.eval_again = text_path && r_bs && !esc_ok;
        o_st.flush_last = flush_last;
        o_st.end_flush  = r_last && (r_phase == PH_ENTITY);
        o_st.end_bsl    = r_last && r_bs;
    end

    always_comb begin
        n_mode   = r_mode;
        n_hdr    = r_hdr;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bs     = r_bs;
        n_len    = r_len;
        n_fidx   = r_fidx;
        buf_we   = 1'b0;
        buf_wd   = r_c;
        buf_wa   = r_len[IDX_W-1:0];
        put_en   = 1'b0;
        put_byte = r_c;
        if (i_cmd.eval) begin
            if (text_path) begin
                n_phase = PH_TEXT;
                if (r_bs) begin
                    n_bs   = 1'b0;
                    put_en = 1'b1;
                    if (r_c == CH_N || r_c == CH_UPN)
                        put_byte = CH_NL;
                    else if (r_c == CH_H && r_mode <= MODE_VTT)
                        put_byte = CH_SPACE;
                    else
                        put_byte = CH_BSL;
                end else if (r_mode == MODE_PASS) begin
                    put_en = 1'b1;
                end else if ((r_mode == MODE_ASS && r_c == CH_LBR)
                             || (r_mode != MODE_ASS && r_c == CH_LT)) begin
                    n_phase = PH_TAG;
                end else if (r_c == CH_BSL) begin
                    n_bs = 1'b1;
                end else if (r_mode == MODE_VTT && r_c == CH_AMP) begin
                    buf_we  = 1'b1;
                    buf_wa  = '0;
                    n_len   = LEN_W'(1);
                    n_phase = PH_ENTITY;
                end else begin
                    put_en = 1'b1;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_c == CH_COMMA) begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= r_hdr)
                                n_phase = PH_EXTRA;
                        end
                    end
                    PH_EXTRA: n_phase = PH_TEXT;
                    PH_TAG: begin
                        if (r_c == ((r_mode == MODE_ASS) ? CH_RBR : CH_GT))
                            n_phase = PH_TEXT;
                    end
                    PH_ENTITY: begin
                        if (ent_done) begin
                            put_en   = 1'b1;
                            put_byte = ent_val;
                            n_len    = '0;
                            n_phase  = PH_TEXT;
                        end else begin
                            buf_we = 1'b1;
                            n_len  = r_len + LEN_W'(1);
                        end
                    end
                    default: n_phase = PH_TEXT;
                endcase
            end
        end
        if (i_cmd.flush) begin
            put_en   = 1'b1;
            put_byte = r_buf[r_fidx];
            n_fidx   = r_fidx + IDX_W'(1);
            if (flush_last) begin
                n_fidx  = '0;
                n_len   = '0;
                n_phase = PH_TEXT;
            end
        end
        if (i_cmd.bsl) begin
            put_en   = 1'b1;
            put_byte = CH_BSL;
            n_bs     = 1'b0;
        end
        if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE)
                n_mode = i_cfg_data[1:0];
            else
                n_hdr = i_cfg_data;
        end
        if ((i_cmd.finish && r_last) || i_cfg_we) begin
            n_phase = (n_mode == MODE_ASS) ? ((n_hdr != '0) ? PH_HEADER : PH_EXTRA) : PH_TEXT;
            n_cnt   = '0;
            n_bs    = 1'b0;
            n_len   = '0;
        end
    end

    // one byte stays in the hold register so the line end can mark it
    always_comb begin
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_ov     = r_ov && !i_m_tready;
        n_ob     = r_ob;
        n_obv    = r_obv;
        n_ol     = r_ol;
        if (put_en) begin
            if (r_hold_v) begin
                n_ov  = 1'b1;
                n_ob  = r_hold;
                n_obv = 1'b1;
                n_ol  = 1'b0;
            end
            n_hold_v = 1'b1;
            n_hold   = put_byte;
        end
        if (i_cmd.finish) begin
            if (r_hold_v) begin
                n_ov  = 1'b1;
                n_ob  = r_hold;
                n_obv = 1'b1;
                n_ol  = r_last;
            end else if (r_last) begin
                n_ov  = 1'b1;
                n_ob  = '0;
                n_obv = 1'b0;
                n_ol  = 1'b1;
            end
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ASS;
            r_hdr    <= COMMAS_RESET;
            r_phase  <= PH_HEADER;
            r_cnt    <= '0;
            r_bs     <= 1'b0;
            r_len    <= '0;
            r_fidx   <= '0;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_hdr    <= n_hdr;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_bs     <= n_bs;
            r_len    <= n_len;
            r_fidx   <= n_fidx;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_ob   <= n_ob;
        r_obv  <= n_obv;
        r_ol   <= n_ol;
        if (i_cmd.accept) begin
            r_c    <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (buf_we)
            r_buf[buf_wa] <= buf_wd;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_ob;
    assign o_m_tuser  = r_obv;
    assign o_m_tlast  = r_ol;

endmodule

### sv/subtitle_markup_stripper.sv
// Subtitle markup stripper top level: sequencer plus datapath.
//
// One input byte is taken at a time and passes through accept, evaluate and
// line-end check. An unknown escape is evaluated again to emit its extra byte,
// and a trailing backslash is emitted in the line-end check. An entity mismatch,
// or an entity still open at the line end, leads to a flush state that replays
// the buffered bytes (up to five) one byte per cycle, while the sink keeps up,
// through a single hold register, then returns to the step it came from. Any step
// stalls while the output register holds an item the sink has not taken. The last
// byte of a line carries tlast; a line that ends with no byte gives one item with
// tuser 0 and tdata 0. Configuration writes reset the line state and must be made between items.
module subtitle_markup_stripper #(
    parameter int LOOKAHEAD_DEPTH = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] char_out
    output logic       o_m_tuser,   // [0] char_valid
    output logic       o_m_tlast
);
    import sms_pkg::*;

    t_cmd    cmd;
    t_status st;

    sms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sms_dp #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_cmd      (cmd),
        .o_st       (st),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

### sv/sms_chk.sv
// Port-level checks for the subtitle markup stripper, bound to the top level.
module sms_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser,
    input logic       o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output item changed while stalled");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && o_m_tdata == 8'h00)
        else $error("end marker without tlast or with data");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in work");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind subtitle_markup_stripper sms_chk u_chk (.*);

### verif/tb_subtitle_markup_stripper.sv
// Self-checking testbench for the subtitle markup stripper: directed lines, then random lines.
module tb_subtitle_markup_stripper;
    timeunit 1ns;
    timeprecision 1ps;

    import sms_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int SEND_IDLE [4]  = '{0, 48, 0, 14};
    localparam int RECV_STALL [4] = '{0, 0, 48, 14};

    typedef enum logic [2:0] {PH_HEADER, PH_EXTRA, PH_TEXT, PH_TAG, PH_ENTITY} t_strip_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       last;
    } t_out_item;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_idx  = 1'b0;
    logic [3:0] i_cfg_data = 4'd0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'd0;   // [7:0] char_in
    logic       i_s_tlast  = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] char_out
    logic       o_m_tuser;           // [0] char_valid
    logic       o_m_tlast;

    subtitle_markup_stripper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0]   p_mode   = MODE_ASS;
    logic [3:0]   p_commas = COMMAS_RESET;
    t_strip_phase p_phase;
    logic [3:0]   p_comma_cnt;
    logic         p_bsl;
    logic [7:0]   p_ebuf [ENT_MAX];
    int           p_elen;

    logic [7:0] emit_q [$];
    t_out_item  cleaned_q [$];
    logic [7:0] line_q [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int n_items_in    = 0;
    int n_items_out   = 0;
    int n_writes      = 0;
    int n_errors      = 0;
    int quiet_cycles  = 0;

    t_out_item got_item;
    t_out_item want_item;

    function automatic void line_reset();
        if (p_mode == MODE_ASS)
            p_phase = (p_commas != 4'd0) ? PH_HEADER : PH_EXTRA;
        else
            p_phase = PH_TEXT;
        p_comma_cnt = 4'd0;
        p_bsl       = 1'b0;
        p_elen      = 0;
    endfunction

    function automatic void text_char(input logic [7:0] c);
        if (p_bsl) begin
            p_bsl = 1'b0;
            if (c == CH_N || c == CH_UPN) begin
                emit_q.push_back(CH_NL);
                return;
            end
            if (c == CH_H && (p_mode == MODE_ASS || p_mode == MODE_VTT)) begin
                emit_q.push_back(CH_SPACE);
                return;
            end
            emit_q.push_back(CH_BSL);
        end
        if (p_mode == MODE_PASS) begin
            emit_q.push_back(c);
            return;
        end
        if ((p_mode == MODE_ASS && c == CH_LBR) || (p_mode != MODE_ASS && c == CH_LT)) begin
            p_phase = PH_TAG;
            return;
        end
        if (c == CH_BSL) begin
            p_bsl = 1'b1;
            return;
        end
        if (p_mode == MODE_VTT && c == CH_AMP) begin
            p_ebuf[0] = CH_AMP;
            p_elen    = 1;
            p_phase   = PH_ENTITY;
            return;
        end
        emit_q.push_back(c);
    endfunction

    function automatic void entity_flush();
        int i;
        emit_q.push_back(CH_AMP);
        for (i = 1; i < p_elen && i < ENT_MAX; i++)
            emit_q.push_back(p_ebuf[i]);
        p_elen  = 0;
        p_phase = PH_TEXT;
    endfunction

    function automatic void entity_char(input logic [7:0] c);
        int  held;
        int  k;
        int  i;
        bit  same;
        held = p_elen;
        if (held >= 1 && held < ENT_MAX) begin
            for (k = 0; k < ENT_NUM; k++) begin
                same = int'(ENT_SIZE[k]) > held;
                for (i = 0; same && i < held; i++)
                    if (p_ebuf[i] != ENT_TEXT[k][i])
                        same = 1'b0;
                if (!same || ENT_TEXT[k][held] != c)
                    continue;
                if (int'(ENT_SIZE[k]) == held + 1) begin
                    emit_q.push_back(ENT_VALUE[k]);
                    p_elen  = 0;
                    p_phase = PH_TEXT;
                end else begin
                    p_ebuf[held] = c;
                    p_elen       = held + 1;
                end
                return;
            end
        end
        entity_flush();
        text_char(c);
    endfunction

    // works out the cleaned bytes one accepted item gives
    function automatic void predict_cleaned(input logic [7:0] c, input logic last);
        t_out_item item;
        int        k;
        emit_q.delete();
        case (p_phase)
            PH_HEADER: begin
                if (c == CH_COMMA) begin
                    p_comma_cnt = p_comma_cnt + 4'd1;
                    if (p_comma_cnt >= p_commas)
                        p_phase = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                p_phase = PH_TEXT;
                if (c != CH_COMMA)
                    text_char(c);
            end
            PH_TAG: begin
                if (c == ((p_mode == MODE_ASS) ? CH_RBR : CH_GT))
                    p_phase = PH_TEXT;
            end
            PH_ENTITY: begin
                entity_char(c);
            end
            default: begin
                p_phase = PH_TEXT;
                text_char(c);
            end
        endcase
        if (last) begin
            if (p_phase == PH_ENTITY)
                entity_flush();
            if (p_bsl)
                emit_q.push_back(CH_BSL);
            line_reset();
        end
        for (k = 0; k < emit_q.size(); k++) begin
            item.ch    = emit_q[k];
            item.valid = 1'b1;
            item.last  = last && (k == emit_q.size() - 1);
            cleaned_q.push_back(item);
        end
        if (last && emit_q.size() == 0) begin
            item.ch    = 8'h00;
            item.valid = 1'b0;
            item.last  = 1'b1;
            cleaned_q.push_back(item);
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // one subtitle line: mostly well-formed header and markup, some noise
    function automatic void build_line(input logic [1:0] md, input logic [3:0] commas);
        int         n_tok;
        int         t;
        int         j;
        int         k;
        int         len;
        logic [7:0] open_ch;
        logic [7:0] close_ch;
        line_q.delete();
        if (md == MODE_ASS) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(commas)) : int'(commas);
            for (j = 0; j < k; j++) begin
                repeat ($urandom_range(0, 1)) line_q.push_back(rand_letter());
                line_q.push_back(CH_COMMA);
            end
            if ($urandom_range(0, 2) == 0)
                line_q.push_back(CH_COMMA);
        end
        n_tok = $urandom_range(1, 6);
        for (t = 0; t < n_tok; t++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: line_q.push_back(rand_letter());
                3: line_q.push_back(8'($urandom_range(1, 255)));
                4: begin
                    line_q.push_back(CH_BSL);
                    case ($urandom_range(0, 3))
                        0: line_q.push_back(CH_N);
                        1: line_q.push_back(CH_UPN);
                        2: line_q.push_back(CH_H);
                        default: line_q.push_back(8'($urandom_range(1, 255)));
                    endcase
                end
                5: begin
                    open_ch  = (md == MODE_ASS) ? CH_LBR : CH_LT;
                    close_ch = (md == MODE_ASS) ? CH_RBR : CH_GT;
                    if ($urandom_range(0, 4) == 0) begin
                        open_ch  = (md == MODE_ASS) ? CH_LT : CH_LBR;
                        close_ch = (md == MODE_ASS) ? CH_GT : CH_RBR;
                    end
                    line_q.push_back(open_ch);
                    repeat ($urandom_range(0, 3)) line_q.push_back(rand_letter());
                    if ($urandom_range(0, 5) != 0)
                        line_q.push_back(close_ch);
                end
                6, 7: begin
                    k   = $urandom_range(0, ENT_NUM - 1);
                    len = int'(ENT_SIZE[k]);
                    if ($urandom_range(0, 2) == 0)
                        len = $urandom_range(1, int'(ENT_SIZE[k]) - 1);
                    for (j = 0; j < len; j++)
                        line_q.push_back(ENT_TEXT[k][j]);
                end
                8: line_q.push_back(CH_COMMA);
                default: begin
                    case ($urandom_range(0, 3))
                        0: line_q.push_back(CH_AMP);
                        1: line_q.push_back(CH_BSL);
                        2: line_q.push_back(CH_RBR);
                        default: line_q.push_back(CH_GT);
                    endcase
                end
            endcase
        end
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic [7:0] c, input logic last);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        n_items_in++;
        predict_cleaned(c, last);
    endtask

    task automatic send_line();
        int j;
        for (j = 0; j < line_q.size(); j++)
            send_item(line_q[j], j == line_q.size() - 1);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (cleaned_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after its last write
    task automatic write_reg(input logic idx, input logic [3:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == REG_MODE)
            p_mode = val[1:0];
        else
            p_commas = val;
        line_reset();
        n_writes++;
    endtask

    task automatic configure(input logic [1:0] md, input logic [3:0] commas, input int row);
        drain();
        write_reg(REG_MODE, {2'b00, md});
        write_reg(REG_COMMAS, commas);
        i_cfg_we <= 1'b0;
        send_idle_pct = SEND_IDLE[row];
        stall_pct     = RECV_STALL[row];
    endtask

    // header skip with extra comma, override block, \h, unknown escape, trailing backslash
    task automatic test_ass_cleanup();
        configure(MODE_ASS, 4'd1, 0);
        line_q = '{CH_COMMA, CH_COMMA, CH_LBR, 8'h78, CH_RBR, CH_BSL, CH_H,
                   CH_BSL, 8'h71, CH_BSL};
        send_line();
    endtask

    // line ends inside the header: only the end marker comes out
    task automatic test_header_cut_short();
        line_q = '{8'h01, 8'hFF};
        send_line();
    endtask

    // decoded entity, entity mismatch replay, open tag at line end, entity open at line end
    task automatic test_vtt_entities();
        configure(MODE_VTT, 4'd1, 0);
        line_q = '{CH_AMP, 8'h6C, 8'h74, 8'h3B, CH_AMP, 8'h61, 8'h78, CH_LT, 8'h69};
        send_line();
        line_q = '{CH_AMP, 8'h6E, 8'h62};
        send_line();
    endtask

    task automatic test_srt_and_passthrough();
        configure(MODE_SRT, 4'd1, 0);
        line_q = '{CH_BSL, CH_H};
        send_line();
        configure(MODE_PASS, 4'd1, 0);
        line_q = '{CH_BSL, CH_LT};
        send_line();
    endtask

    // sink holds off while the source keeps offering, so the block backs up
    task automatic test_output_backpressure();
        int j;
        configure(MODE_PASS, 4'd0, 0);
        hold_req = HOLD_CYCLES;
        line_q.delete();
        for (j = 0; j < 20; j++)
            line_q.push_back(rand_letter());
        send_line();
    endtask

    task automatic test_random_lines(input logic [1:0] md, input logic [3:0] commas,
                                     input int row, input int n_items);
        int sent;
        configure(md, commas, row);
        sent = 0;
        while (sent < n_items) begin
            build_line(md, commas);
            sent += line_q.size();
            send_line();
        end
    endtask

    // sink: random stalls, plus one long counted hold on request
    initial begin
        int hold_len;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_len = hold_req;
                hold_req = 0;
                i_m_tready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_items_out++;
            got_item = '{o_m_tdata, o_m_tuser, o_m_tlast};
            if (cleaned_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item: actual ch=%h valid=%b last=%b",
                         $time, got_item.ch, got_item.valid, got_item.last);
            end else begin
                want_item = cleaned_q.pop_front();
                if (got_item !== want_item) begin
                    n_errors++;
                    $display("%0t: expected ch=%h valid=%b last=%b, actual ch=%h valid=%b last=%b",
                             $time, want_item.ch, want_item.valid, want_item.last,
                             got_item.ch, got_item.valid, got_item.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, cleaned_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        line_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ass_cleanup();
        test_header_cut_short();
        test_vtt_entities();
        test_srt_and_passthrough();
        test_output_backpressure();

        test_random_lines(MODE_ASS,  COMMAS_RESET, 0, 10);
        test_random_lines(MODE_VTT,  4'd0,         1, 10);
        test_random_lines(MODE_ASS,  4'd0,         2, 10);
        test_random_lines(MODE_SRT,  4'd0,         3, 10);
        test_random_lines(MODE_ASS,  4'd15,        0, 10);
        test_random_lines(MODE_PASS, 4'd0,         1, 10);
        test_random_lines(MODE_VTT,  4'd2,         2, 10);
        test_random_lines(MODE_ASS,  4'd3,         3, 10);
        drain();

        $display("Run covered %0d input items and %0d output items with %0d register writes,",
                 n_items_in, n_items_out, n_writes);
        $display("all four modes, header lengths 0 to 15, entities, escapes and a long sink stall.");
        if (cleaned_q.size() != 0)
            $display("%0t: %0d expected items never arrived", $time, cleaned_q.size());
        if (n_errors == 0 && cleaned_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
sv/sms_pkg.sv
sv/sms_ctrl.sv
sv/sms_dp.sv
sv/subtitle_markup_stripper.sv
sv/sms_chk.sv
verif/tb_subtitle_markup_stripper.sv
